[hdl/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands shared by the RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked on every edge outside reset
`define ASSERT_CLK(lbl, clk_s, rst_s, prop, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) prop) else $error(msg);

// checked on every edge, reset included
`define ASSERT_ALWAYS(lbl, clk_s, prop, msg) \
  lbl: assert property (@(posedge clk_s) prop) else $error(msg);

`endif

[hdl/trpd_pkg.sv]
// ----------------------------------------------------------------------------
// trpd_pkg
// Types and constants of the tri-state remote pulse decoder.
// ----------------------------------------------------------------------------
package trpd_pkg;

  localparam int SYMBOLS  = 11;
  localparam int PULSES   = 2 * SYMBOLS;
  localparam int CODE_W   = 2 * SYMBOLS;
  localparam int COUNT_W  = 5;
  localparam int WIDTH_W  = 16;
  localparam int ADDR_W   = 5;
  localparam int DATA_W   = 32;
  localparam int MATCH_SYMBOLS = 8;

  localparam logic [WIDTH_W-1:0] HEADER_MIN_RST = 16'd3100;
  localparam logic [WIDTH_W-1:0] HEADER_MAX_RST = 16'd3800;
  localparam logic [WIDTH_W-1:0] LONG_MIN_RST   = 16'd250;
  localparam logic [WIDTH_W-1:0] LONG_MAX_RST   = 16'd500;
  localparam logic [WIDTH_W-1:0] SHORT_MIN_RST  = 16'd50;
  localparam logic [WIDTH_W-1:0] SHORT_MAX_RST  = 16'd200;

  localparam logic [COUNT_W-1:0] LAST_COUNT = COUNT_W'(PULSES);

  localparam logic [1:0] SYM_ZERO  = 2'd0;
  localparam logic [1:0] SYM_ONE   = 2'd1;
  localparam logic [1:0] SYM_FLOAT = 2'd2;

  typedef enum logic [2:0] {
    REG_HEADER_MIN = 3'd0,
    REG_HEADER_MAX = 3'd1,
    REG_LONG_MIN   = 3'd2,
    REG_LONG_MAX   = 3'd3,
    REG_SHORT_MIN  = 3'd4,
    REG_SHORT_MAX  = 3'd5
  } reg_index_t;

  typedef enum logic [1:0] {
    CMD_NONE  = 2'd0,
    CMD_SYM10 = 2'd1,
    CMD_SYM9  = 2'd2,
    CMD_SYM8  = 2'd3
  } command_t;

  typedef struct packed {
    logic [CODE_W-1:0] symbol_code;
    logic              address_match;
    command_t          command;
  } result_t;

endpackage

[hdl/tristate_remote_pulse_decoder_core.sv]
// ----------------------------------------------------------------------------
// tristate_remote_pulse_decoder_core
// Header detection, pulse classing and frame decode for tri-state remotes.
// ----------------------------------------------------------------------------
// Throughput: one pulse word accepted per cycle while pulse_stall is low, set by
//   the single compare and count stage.
// Output: the code word is valid in the cycle after the 22nd data pulse is accepted.
// Reset: clears the frame count and output valid, restores register defaults.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module tristate_remote_pulse_decoder_core (
  input  logic                          clk,
  input  logic                          rst,
  // APB configuration
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [trpd_pkg::ADDR_W-1:0]   paddr,
  input  logic [trpd_pkg::DATA_W-1:0]   pwdata,
  output logic [trpd_pkg::DATA_W-1:0]   prdata,
  output logic                          pready,
  // pulse words
  input  logic                          pulse_valid,
  output logic                          pulse_stall,
  input  logic                          cmd,
  input  logic [trpd_pkg::WIDTH_W-1:0]  pulse_width,
  // code words
  output logic                          code_valid,
  input  logic                          code_stall,
  output logic [trpd_pkg::CODE_W-1:0]   symbol_code,
  output logic                          address_match,
  output logic [1:0]                    command
);

  logic [trpd_pkg::WIDTH_W-1:0] header_min, header_max;
  logic [trpd_pkg::WIDTH_W-1:0] long_min, long_max;
  logic [trpd_pkg::WIDTH_W-1:0] short_min, short_max;

  logic [trpd_pkg::COUNT_W-1:0] pulse_count, pulse_count_next;
  logic [trpd_pkg::PULSES-2:0]  pulse_is_short;
  logic [trpd_pkg::PULSES-1:0]  frame_bits;

  trpd_pkg::result_t            result, frame_result;

  trpd_pkg::reg_index_t         reg_sel;
  logic                         wr_en;
  logic                         accept;
  logic                         idle;
  logic                         in_header, in_long, in_short;
  logic                         classed;
  logic                         emit;

  // configuration port
  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready;
  assign reg_sel = trpd_pkg::reg_index_t'(paddr[trpd_pkg::ADDR_W-1:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      header_min <= trpd_pkg::HEADER_MIN_RST;
      header_max <= trpd_pkg::HEADER_MAX_RST;
      long_min   <= trpd_pkg::LONG_MIN_RST;
      long_max   <= trpd_pkg::LONG_MAX_RST;
      short_min  <= trpd_pkg::SHORT_MIN_RST;
      short_max  <= trpd_pkg::SHORT_MAX_RST;
    end else if (wr_en) begin
      unique case (reg_sel)
        trpd_pkg::REG_HEADER_MIN: header_min <= pwdata[trpd_pkg::WIDTH_W-1:0];
        trpd_pkg::REG_HEADER_MAX: header_max <= pwdata[trpd_pkg::WIDTH_W-1:0];
        trpd_pkg::REG_LONG_MIN:   long_min   <= pwdata[trpd_pkg::WIDTH_W-1:0];
        trpd_pkg::REG_LONG_MAX:   long_max   <= pwdata[trpd_pkg::WIDTH_W-1:0];
        trpd_pkg::REG_SHORT_MIN:  short_min  <= pwdata[trpd_pkg::WIDTH_W-1:0];
        trpd_pkg::REG_SHORT_MAX:  short_max  <= pwdata[trpd_pkg::WIDTH_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      trpd_pkg::REG_HEADER_MIN: prdata = {16'd0, header_min};
      trpd_pkg::REG_HEADER_MAX: prdata = {16'd0, header_max};
      trpd_pkg::REG_LONG_MIN:   prdata = {16'd0, long_min};
      trpd_pkg::REG_LONG_MAX:   prdata = {16'd0, long_max};
      trpd_pkg::REG_SHORT_MIN:  prdata = {16'd0, short_min};
      trpd_pkg::REG_SHORT_MAX:  prdata = {16'd0, short_max};
      default:                  prdata = '0;
    endcase
  end

  // pulse classing
  assign pulse_stall = code_valid && code_stall;
  assign accept      = pulse_valid && !pulse_stall;

  assign in_header = (pulse_width >= header_min) && (pulse_width <= header_max);
  assign in_long   = (pulse_width >= long_min) && (pulse_width <= long_max);
  assign in_short  = (pulse_width >= short_min) && (pulse_width <= short_max);

  assign idle    = (pulse_count == '0) || (pulse_count > trpd_pkg::LAST_COUNT);
  assign classed = !cmd && !idle && (in_long || in_short);
  assign emit    = accept && classed && (pulse_count == trpd_pkg::LAST_COUNT);

  always_comb begin
    priority if (cmd) begin
      pulse_count_next = '0;
    end else if (idle) begin
      pulse_count_next = in_header ? trpd_pkg::COUNT_W'(1) : '0;
    end else if (!classed || pulse_count == trpd_pkg::LAST_COUNT) begin
      pulse_count_next = '0;
    end else begin
      pulse_count_next = pulse_count + trpd_pkg::COUNT_W'(1);
    end
  end

  // pulse k of the frame lands in bit k after the 21st shift
  assign frame_bits = {!in_long, pulse_is_short};

  trpd_symbols u_symbols (
    .is_short (frame_bits),
    .result   (frame_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      pulse_count <= '0;
      code_valid  <= 1'b0;
    end else begin
      if (accept) begin
        pulse_count <= pulse_count_next;
      end
      if (emit) begin
        code_valid <= 1'b1;
      end else if (!code_stall) begin
        code_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && classed) begin
      pulse_is_short <= {!in_long, pulse_is_short[trpd_pkg::PULSES-2:1]};
    end
    if (emit) begin
      result <= frame_result;
    end
  end

  assign symbol_code   = result.symbol_code;
  assign address_match = result.address_match;
  assign command       = result.command;

  `ASSERT_ALWAYS(a_pready_high, clk, pready, "pready dropped")
  `ASSERT_CLK(a_count_range, clk, rst, pulse_count <= trpd_pkg::LAST_COUNT, "frame count out of range")
  `ASSERT_CLK(a_timeout_clears, clk, rst, (accept && cmd) |=> (pulse_count == '0), "timeout did not drop frame")
  `ASSERT_CLK(a_cmd_needs_match, clk, rst, (code_valid && !address_match) |-> (command == trpd_pkg::CMD_NONE), "command without address match")

endmodule

[hdl/trpd_symbols.sv]
// ----------------------------------------------------------------------------
// trpd_symbols
// Pairs the 22 classed pulses into tri-state symbols and derives the command.
// ----------------------------------------------------------------------------
module trpd_symbols (
  input  logic [trpd_pkg::PULSES-1:0] is_short,
  output trpd_pkg::result_t           result
);

  logic [trpd_pkg::CODE_W-1:0] code;
  logic                        match;

  always_comb begin
    for (int i = 0; i < trpd_pkg::SYMBOLS; i++) begin
      if (is_short[2*i] == is_short[2*i+1]) begin
        code[2*i +: 2] = is_short[2*i] ? trpd_pkg::SYM_ONE : trpd_pkg::SYM_ZERO;
      end else begin
        code[2*i +: 2] = trpd_pkg::SYM_FLOAT;
      end
    end
  end

  assign match = (code[2*trpd_pkg::MATCH_SYMBOLS-1:0] == '0);

  always_comb begin
    result.symbol_code   = code;
    result.address_match = match;
    priority if (!match) begin
      result.command = trpd_pkg::CMD_NONE;
    end else if (code[21:20] == trpd_pkg::SYM_ONE) begin
      result.command = trpd_pkg::CMD_SYM10;
    end else if (code[19:18] == trpd_pkg::SYM_ONE) begin
      result.command = trpd_pkg::CMD_SYM9;
    end else if (code[17:16] == trpd_pkg::SYM_ONE) begin
      result.command = trpd_pkg::CMD_SYM8;
    end else begin
      result.command = trpd_pkg::CMD_NONE;
    end
  end

endmodule
